@@ rtl/core/elevation_grid_mean_map_assert.svh @@
// Assertion macros for the elevation grid map RTL.
// Needs nothing else; included by egmm_ctrl, which checks its own control.
`ifndef ELEVATION_GRID_MEAN_MAP_ASSERT_SVH
`define ELEVATION_GRID_MEAN_MAP_ASSERT_SVH

// same-cycle implication, off while reset is held
`define EGMM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define EGMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/egmm_pkg.sv @@
// Shared constants, opcodes and controller/datapath bundles of the elevation grid map.
// No dependencies; every RTL module refers to it by scoped names.
`default_nettype none

package egmm_pkg;

    localparam int GRID_SIZE       = 400;
    localparam int COUNT_WIDTH     = 18;
    localparam int CELL_MM         = 10;
    localparam int CELL_TOTAL      = GRID_SIZE * GRID_SIZE;
    localparam int HALF_SPAN       = GRID_SIZE * CELL_MM / 2;
    localparam int FULL_SPAN       = GRID_SIZE * CELL_MM;
    localparam int COL_SHIFT_MM    = (GRID_SIZE / 2) * CELL_MM;
    localparam int SUM_WIDTH       = COUNT_WIDTH + 16;
    localparam int ENTRY_WIDTH     = SUM_WIDTH + COUNT_WIDTH;
    localparam int ADDR_WIDTH      = $clog2(CELL_TOTAL);
    localparam int COORD_WIDTH     = 9;
    localparam int COORD_IN_WIDTH  = 16;
    localparam int MEAN_WIDTH      = 16;
    localparam int OUT_COUNT_WIDTH = 18;
    localparam int THR_WIDTH       = 15;
    localparam int PROD_WIDTH      = THR_WIDTH + COUNT_WIDTH;
    localparam int CMP_WIDTH       = SUM_WIDTH + 1;
    localparam int DIV_CNT_WIDTH   = $clog2(SUM_WIDTH + 1);

    localparam logic [THR_WIDTH-1:0]   THR_RESET = THR_WIDTH'(100);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // floor(v / CELL_MM) for any 16-bit unsigned v: (v * BIN_RECIP) >> BIN_SHIFT
    localparam int               BIN_RECIP_WIDTH = 17;
    localparam int               BIN_PROD_WIDTH  = COORD_IN_WIDTH + BIN_RECIP_WIDTH;
    localparam int               BIN_SHIFT       = 19;
    localparam int               QUOT_WIDTH      = BIN_PROD_WIDTH - BIN_SHIFT;
    localparam logic [BIN_RECIP_WIDTH-1:0] BIN_RECIP = BIN_RECIP_WIDTH'(52429);

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_CLEAR = 2'd0;
    localparam t_opcode OP_ADD   = 2'd1;
    localparam t_opcode OP_READ  = 2'd2;

    typedef struct packed {
        logic capture;
        logic bin;
        logic addr;
        logic rd;
        logic modify;
        logic div_start;
        logic clr_run;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/core/egmm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the cell mean.
// Depends on egmm_pkg for the sum and count widths.
`default_nettype none

module egmm_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [egmm_pkg::SUM_WIDTH-1:0]   i_dividend,
    input  wire logic [egmm_pkg::COUNT_WIDTH-1:0] i_divisor,
    output logic                                  o_busy,
    output logic [egmm_pkg::SUM_WIDTH-1:0]        o_quotient
);

    localparam int SW = egmm_pkg::SUM_WIDTH;
    localparam int CW = egmm_pkg::COUNT_WIDTH;
    localparam int NW = egmm_pkg::DIV_CNT_WIDTH;

    logic          r_busy, n_busy;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rem, n_rem;
    logic [SW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_dsr, n_dsr;

    logic [CW:0]   rem_sh;
    logic          ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[SW-1]};
        ge     = rem_sh >= {1'b0, r_dsr};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = NW'(SW);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            // shift the next dividend bit in; quotient bits fill from the bottom
            n_rem  = ge ? CW'(rem_sh - {1'b0, r_dsr}) : CW'(rem_sh);
            n_quo  = {r_quo[SW-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            n_busy = (r_cnt != NW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ rtl/core/egmm_ctrl.sv @@
// Sequencer of the elevation grid map: clear sweep, bin, cell read-modify-write, divide, report.
// Depends on egmm_pkg (opcodes, command and status bundles) and the assertion macro header.
`default_nettype none
`include "elevation_grid_mean_map_assert.svh"

module egmm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire egmm_pkg::t_opcode i_opcode,
    input  wire egmm_pkg::t_sts    i_sts,
    output logic                   o_stall,
    output egmm_pkg::t_cmd         o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CLR  = 4'd1;
    localparam logic [3:0] ST_BIN  = 4'd2;
    localparam logic [3:0] ST_ADDR = 4'd3;
    localparam logic [3:0] ST_READ = 4'd4;
    localparam logic [3:0] ST_MOD  = 4'd5;
    localparam logic [3:0] ST_PREP = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_pend, n_pend;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_opcode == egmm_pkg::OP_CLEAR) begin
                        n_state = ST_CLR;
                        n_pend  = 1'b1;
                    end else begin
                        n_state = ST_BIN;
                    end
                end
            end
            ST_CLR: begin
                o_cmd.clr_run = 1'b1;
                // the sweep after reset has no beat to report
                if (i_sts.clr_last) begin
                    n_state = r_pend ? ST_DONE : ST_IDLE;
                end
            end
            ST_BIN: begin
                o_cmd.bin = 1'b1;
                n_state   = ST_ADDR;
            end
            ST_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = ST_READ;
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.modify = 1'b1;
                n_state      = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_pend         = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    assign o_stall = (r_state != ST_IDLE);

    `EGMM_ASSERT_IMPL(a_load_only_when_free, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free, "result loaded over an untaken beat")
    `EGMM_ASSERT_NEXT(a_clear_starts_sweep, i_clk, i_rst_n, (r_state == ST_IDLE) && i_valid && (i_opcode == egmm_pkg::OP_CLEAR), (r_state == ST_CLR) && r_pend, "clear beat did not start the sweep")
    `EGMM_ASSERT_IMPL(a_div_idle_at_done, i_clk, i_rst_n, r_state == ST_DONE, !i_sts.div_busy, "reporting while the divider still runs")

endmodule

`default_nettype wire

@@ rtl/core/egmm_dp.sv @@
// Datapath of the elevation grid map: binning, cell store, mean and obstacle test, output register.
// Depends on egmm_pkg and on egmm_div for the mean division.
`default_nettype none

module egmm_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire egmm_pkg::t_cmd                        i_cmd,
    output egmm_pkg::t_sts                             o_sts,
    input  wire egmm_pkg::t_opcode                     i_opcode,
    input  wire logic signed [15:0]                    i_point_x_mm,
    input  wire logic signed [15:0]                    i_point_y_mm,
    input  wire logic signed [15:0]                    i_point_z_mm,
    input  wire logic [egmm_pkg::COORD_WIDTH-1:0]      i_read_row,
    input  wire logic [egmm_pkg::COORD_WIDTH-1:0]      i_read_col,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [egmm_pkg::THR_WIDTH-1:0]        i_cfg_wr_data,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_accepted,
    output logic [egmm_pkg::COORD_WIDTH-1:0]           o_cell_row,
    output logic [egmm_pkg::COORD_WIDTH-1:0]           o_cell_col,
    output logic signed [egmm_pkg::MEAN_WIDTH-1:0]     o_mean_height_mm,
    output logic [egmm_pkg::OUT_COUNT_WIDTH-1:0]       o_point_count,
    output logic                                       o_obstacle
);

    localparam int SW  = egmm_pkg::SUM_WIDTH;
    localparam int CW  = egmm_pkg::COUNT_WIDTH;
    localparam int AW  = egmm_pkg::ADDR_WIDTH;
    localparam int QW  = egmm_pkg::QUOT_WIDTH;
    localparam int RW  = egmm_pkg::COORD_WIDTH;
    localparam int IW  = egmm_pkg::COORD_IN_WIDTH;
    localparam int PW  = egmm_pkg::BIN_PROD_WIDTH;
    localparam int MW  = egmm_pkg::MEAN_WIDTH;
    localparam int BW  = IW + 2;

    localparam logic signed [BW-1:0] LIM_HALF  = BW'(egmm_pkg::HALF_SPAN);
    localparam logic signed [BW-1:0] LIM_FULL  = BW'(egmm_pkg::FULL_SPAN);
    localparam logic signed [BW-1:0] COL_SHIFT = BW'(egmm_pkg::COL_SHIFT_MM);
    localparam logic [QW-1:0]        GRID_Q    = QW'(egmm_pkg::GRID_SIZE);

    // captured beat
    egmm_pkg::t_opcode     r_op;
    logic signed [IW-1:0]  r_x, r_y, r_z;
    logic [RW-1:0]         r_rrow, r_rcol;

    // binning and address
    logic                  r_hit;
    logic [QW-1:0]         r_row_q, r_col_q;
    logic                  r_cell_ok;
    logic [AW-1:0]         r_addr;
    logic [RW-1:0]         r_rep_row, r_rep_col;

    // cell store and the updated cell
    logic [egmm_pkg::ENTRY_WIDTH-1:0] r_mem [egmm_pkg::CELL_TOTAL];
    logic [egmm_pkg::ENTRY_WIDTH-1:0] r_rd_data;
    logic [AW-1:0]         r_clr_addr;
    logic signed [SW-1:0]  r_sum;
    logic [CW-1:0]         r_cnt;
    logic                  r_acc;
    logic                  r_neg;
    logic [egmm_pkg::PROD_WIDTH-1:0] r_prod;
    logic [egmm_pkg::THR_WIDTH-1:0]  r_thr;

    logic                  r_out_valid;

    logic signed [BW-1:0]  x_ext, z_ext, vx;
    logic                  win;
    logic [PW-1:0]         col_prod, row_prod;
    logic                  in_grid;
    logic signed [SW-1:0]  cell_sum;
    logic [CW-1:0]         cell_cnt;
    logic                  do_add;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [egmm_pkg::ENTRY_WIDTH-1:0] mem_wd;
    logic [SW-1:0]         sum_mag;
    logic [SW-1:0]         quot;
    logic                  div_busy;
    logic [MW-1:0]         q_low;
    logic [MW-1:0]         mean;
    logic signed [egmm_pkg::CMP_WIDTH-1:0] sum_cmp, prod_cmp;
    logic                  obst;

    // window test and floor division by the cell size
    always_comb begin
        x_ext    = BW'(r_x);
        z_ext    = BW'(r_z);
        vx       = x_ext + COL_SHIFT;
        win      = (x_ext > -LIM_HALF) && (x_ext < LIM_HALF)
                && (z_ext > BW'(0)) && (z_ext < LIM_FULL) && !vx[BW-1];
        col_prod = PW'(vx[IW-1:0]) * PW'(egmm_pkg::BIN_RECIP);
        row_prod = PW'(z_ext[IW-1:0]) * PW'(egmm_pkg::BIN_RECIP);
    end

    assign in_grid = r_hit && (r_row_q < GRID_Q) && (r_col_q < GRID_Q);

    // cell read back; an invalid cell reads as empty
    always_comb begin
        cell_sum = r_cell_ok ? $signed(r_rd_data[egmm_pkg::ENTRY_WIDTH-1:CW]) : '0;
        cell_cnt = r_cell_ok ? r_rd_data[CW-1:0] : '0;
        do_add   = i_cmd.modify && (r_op == egmm_pkg::OP_ADD) && r_cell_ok
                && (cell_cnt != egmm_pkg::COUNT_MAX);
        mem_we   = i_cmd.clr_run || do_add;
        mem_wa   = i_cmd.clr_run ? r_clr_addr : r_addr;
        mem_wd   = i_cmd.clr_run ? '0
                 : {SW'(cell_sum + SW'(r_y)), CW'(cell_cnt + 1'b1)};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_x    <= i_point_x_mm;
            r_y    <= i_point_y_mm;
            r_z    <= i_point_z_mm;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.bin) begin
            if (r_op == egmm_pkg::OP_READ) begin
                r_hit   <= 1'b1;
                r_row_q <= QW'(r_rrow);
                r_col_q <= QW'(r_rcol);
            end else begin
                r_hit   <= (r_op == egmm_pkg::OP_ADD) && win;
                r_row_q <= row_prod[PW-1:egmm_pkg::BIN_SHIFT];
                r_col_q <= col_prod[PW-1:egmm_pkg::BIN_SHIFT];
            end
        end
        if (i_cmd.addr) begin
            r_cell_ok <= in_grid;
            r_addr    <= AW'(AW'(r_row_q) * AW'(egmm_pkg::GRID_SIZE)) + AW'(r_col_q);
            if (r_op == egmm_pkg::OP_READ) begin
                r_rep_row <= r_rrow;
                r_rep_col <= r_rcol;
            end else begin
                r_rep_row <= in_grid ? RW'(r_row_q) : '0;
                r_rep_col <= in_grid ? RW'(r_col_q) : '0;
            end
        end
        if (i_cmd.modify) begin
            r_acc <= do_add;
            if (do_add) begin
                r_sum <= SW'(cell_sum + SW'(r_y));
                r_cnt <= CW'(cell_cnt + 1'b1);
            end else begin
                r_sum <= cell_sum;
                r_cnt <= cell_cnt;
            end
        end
        if (i_cmd.div_start) begin
            r_neg  <= r_sum[SW-1];
            r_prod <= egmm_pkg::PROD_WIDTH'(r_thr) * egmm_pkg::PROD_WIDTH'(r_cnt);
        end
    end

    // clear sweep address, obstacle threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_thr      <= egmm_pkg::THR_RESET;
        end else begin
            if (i_cmd.capture) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clr_run) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
        end
    end

    assign sum_mag = r_sum[SW-1] ? SW'(~r_sum + 1'b1) : SW'(r_sum);

    egmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sum_mag),
        .i_divisor  (r_cnt),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    // mean truncated toward zero; obstacle as sum > threshold * count
    always_comb begin
        q_low    = quot[MW-1:0];
        mean     = (r_cnt == '0) ? '0 : (r_neg ? MW'(~q_low + 1'b1) : q_low);
        sum_cmp  = egmm_pkg::CMP_WIDTH'(r_sum);
        prod_cmp = $signed(egmm_pkg::CMP_WIDTH'(r_prod));
        obst     = (r_cnt != '0) && (sum_cmp > prod_cmp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (r_op == egmm_pkg::OP_CLEAR) begin
                o_accepted       <= 1'b0;
                o_cell_row       <= '0;
                o_cell_col       <= '0;
                o_mean_height_mm <= '0;
                o_point_count    <= '0;
                o_obstacle       <= 1'b0;
            end else begin
                o_accepted       <= r_acc;
                o_cell_row       <= r_rep_row;
                o_cell_col       <= r_rep_col;
                o_mean_height_mm <= $signed(mean);
                o_point_count    <= egmm_pkg::OUT_COUNT_WIDTH'(r_cnt);
                o_obstacle       <= obst;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sts.clr_last = (r_clr_addr == AW'(egmm_pkg::CELL_TOTAL - 1));
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_free = !r_out_valid || !i_stall;

endmodule

`default_nettype wire

@@ rtl/core/elevation_grid_mean_map.sv @@
// Top level of the elevation grid map: sequencer plus datapath with the cell store.
// Depends on egmm_pkg, egmm_ctrl, egmm_dp (and egmm_div below it).
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------------
//   input    | i_valid / o_stall  | opcode, point x/y/z mm, read row/col
//   output   | o_valid / i_stall  | accepted, cell row/col, mean height, count, obstacle
//   config   | i_cfg_wr_en        | i_cfg_wr_data: obstacle threshold in mm
//
// A point, read or no-op beat goes from acceptance to its result beat through
// five sequencer steps around one read-modify-write of the cell store, then the
// bit-serial divider that forms the mean, a step to see it finish and one to load.
// A clear beat writes every entry of the 160000-entry store, in address order, before reporting.
// After reset the same sweep runs with o_stall high; config writes still land.
// The result sits in an output register, so a new beat is taken while it waits on i_stall.
`default_nettype none

module elevation_grid_mean_map (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [1:0]                            i_opcode,
    input  wire logic signed [15:0]                    i_point_x_mm,
    input  wire logic signed [15:0]                    i_point_y_mm,
    input  wire logic signed [15:0]                    i_point_z_mm,
    input  wire logic [egmm_pkg::COORD_WIDTH-1:0]      i_read_row,
    input  wire logic [egmm_pkg::COORD_WIDTH-1:0]      i_read_col,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic                                       o_accepted,
    output logic [egmm_pkg::COORD_WIDTH-1:0]           o_cell_row,
    output logic [egmm_pkg::COORD_WIDTH-1:0]           o_cell_col,
    output logic signed [egmm_pkg::MEAN_WIDTH-1:0]     o_mean_height_mm,
    output logic [egmm_pkg::OUT_COUNT_WIDTH-1:0]       o_point_count,
    output logic                                       o_obstacle,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [egmm_pkg::THR_WIDTH-1:0]        i_cfg_wr_data
);

    egmm_pkg::t_cmd cmd;
    egmm_pkg::t_sts sts;

    egmm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    egmm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_opcode),
        .i_point_x_mm     (i_point_x_mm),
        .i_point_y_mm     (i_point_y_mm),
        .i_point_z_mm     (i_point_z_mm),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_accepted       (o_accepted),
        .o_cell_row       (o_cell_row),
        .o_cell_col       (o_cell_col),
        .o_mean_height_mm (o_mean_height_mm),
        .o_point_count    (o_point_count),
        .o_obstacle       (o_obstacle)
    );

endmodule

`default_nettype wire
